// ===== sv/zip_entry_keyed_byte_checksum_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the keyed byte checksum block.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ZIP_ENTRY_KEYED_BYTE_CHECKSUM_DEFINES_SVH
`define ZIP_ENTRY_KEYED_BYTE_CHECKSUM_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ZEKBC_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zekbc: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define ZEKBC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zekbc: next-cycle check failed");
`else
`define ZEKBC_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ZEKBC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== sv/zekbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zekbc_pkg
// Types and fixed constants shared by the keyed byte checksum block.
// ----------------------------------------------------------------------------
package zekbc_pkg;

   // Request kinds.
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Walk status codes.
   localparam logic [1:0] STATUS_WALKING   = 2'd0;
   localparam logic [1:0] STATUS_FINISHED  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   // Local file header layout.
   localparam logic [31:0] LOCAL_MAGIC    = 32'h04034b50;
   localparam int          SIG_BYTES      = 4;
   localparam int          HEADER_BYTES   = 26;
   localparam int          DESC_BYTES     = 16;
   localparam int          NAME_OWED_POS  = 24;
   localparam logic [4:0]  HDR_FLAGS_POS  = 5'd2;
   localparam logic [4:0]  HDR_CSIZE_POS  = 5'd14;
   localparam logic [4:0]  HDR_NLEN_POS   = 5'd22;
   localparam logic [4:0]  HDR_XLEN_POS   = 5'd24;

   // Name tail matching.
   localparam int           TAIL_MAX   = 11;
   localparam logic [23:0]  SUFFIX_SO  = 24'h2E736F;
   localparam logic [87:0]  SUFFIX_DEX = 88'h636C61737365732E646578;

   // Eight key bytes, first byte in the top lane.
   localparam logic [63:0]  KEY_BYTES  = 64'h632B72336B373A31;

   // One request.
   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      logic       end_of_archive;
      logic [7:0] read_index;
   } req_type;

   // One response.
   typedef struct packed {
      logic [7:0] checksum_byte;
      logic [1:0] walk_status;
   } rsp_type;

   // What the walker hands to the accumulator stage for one byte.
   typedef struct packed {
      logic       add_en;
      logic [7:0] addend;
      logic [1:0] walk_status;
   } walk_out_type;

endpackage

// ===== sv/zip_entry_keyed_byte_checksum.sv =====
`timescale 1ns / 1ps
`include "zip_entry_keyed_byte_checksum_defines.svh"
// ----------------------------------------------------------------------------
// zip_entry_keyed_byte_checksum
// Keyed byte checksum over .so and classes.dex entries of a ZIP byte stream.
// ----------------------------------------------------------------------------
// The block takes one request per clock while req_stall is low: an archive
// byte to walk, or a read of one accumulator cell, and returns exactly one
// response for each. A request taken is held in the middle stage and moves
// into the response register when that register is free; requests may follow
// back to back. The accumulator is a single memory with one read and one
// write per cycle; each archive byte reads its cell when it is taken and
// writes the sum as it moves into the response register, with a bypass for a
// cell that is read in the cycle it is written. After reset the block zeroes
// the accumulator in a sweep over all STORE_BYTES cells, holding req_stall
// high until the sweep is done.
module zip_entry_keyed_byte_checksum #(
   parameter int STORE_BYTES = 256,
   parameter int NAME_LIMIT  = 511
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  zekbc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output zekbc_pkg::rsp_type rsp_data
);
   import zekbc_pkg::*;

   localparam int ADDR_W = $clog2(STORE_BYTES);

   logic [ADDR_W-1:0] mod_tbl [256];
   logic              req_accept;
   logic              byte_strobe;
   logic              clear_busy;
   walk_out_type      walk_out;
   logic [ADDR_W-1:0] walk_cell;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              wr_en;
   logic [7:0]        wr_data;
   logic              s1_move;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_read_ff, s1_read_in;
   logic              s1_add_ff, s1_add_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic [7:0]        s1_addend_ff, s1_addend_in;
   logic [1:0]        s1_status_ff, s1_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Read index folded onto the store depth.
   for (genvar g = 0; g < 256; g++) begin : g_mod
      assign mod_tbl[g] = ADDR_W'(g % STORE_BYTES);
   end

   // Handshake: the middle stage moves when the response register frees up.
   always_comb begin
      s1_move     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall   = clear_busy || (s1_valid_ff && !s1_move);
      req_accept  = req_valid && !req_stall;
      byte_strobe = req_accept && (req_data.kind == KIND_BYTE);
      rd_addr     = (req_data.kind == KIND_READ) ? mod_tbl[req_data.read_index] : walk_cell;
   end

   zekbc_walk #(
      .STORE_BYTES (STORE_BYTES),
      .NAME_LIMIT  (NAME_LIMIT)
   ) u_walk (
      .clock          (clock),
      .reset          (reset),
      .byte_strobe    (byte_strobe),
      .byte_value     (req_data.byte_value),
      .end_of_archive (req_data.end_of_archive),
      .walk_out       (walk_out),
      .add_cell       (walk_cell)
   );

   zekbc_acc #(
      .STORE_BYTES (STORE_BYTES)
   ) u_acc (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_accept),
      .rd_addr    (rd_addr),
      .wr_en      (wr_en),
      .wr_addr    (s1_addr_ff),
      .wr_data    (wr_data),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   // Middle stage: accumulate on the way out, or return the cell for a read.
   always_comb begin
      wr_en   = s1_move && s1_add_ff;
      wr_data = rd_data + s1_addend_ff;

      s1_valid_in  = s1_valid_ff;
      s1_read_in   = s1_read_ff;
      s1_add_in    = s1_add_ff;
      s1_addr_in   = s1_addr_ff;
      s1_addend_in = s1_addend_ff;
      s1_status_in = s1_status_ff;
      if (req_accept) begin
         s1_valid_in  = 1'b1;
         s1_read_in   = (req_data.kind == KIND_READ);
         s1_add_in    = walk_out.add_en;
         s1_addr_in   = rd_addr;
         s1_addend_in = walk_out.addend;
         s1_status_in = walk_out.walk_status;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_move) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.checksum_byte = s1_read_ff ? rd_data : 8'd0;
         rsp_data_in.walk_status   = s1_status_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff   <= s1_read_in;
      s1_add_ff    <= s1_add_in;
      s1_addr_ff   <= s1_addr_in;
      s1_addend_ff <= s1_addend_in;
      s1_status_ff <= s1_status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A held middle stage keeps its cell, so its read data stays meaningful.
   `ZEKBC_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_move, s1_valid_ff && $stable(s1_addr_ff))
   // No accumulation can compete with the clearing sweep.
   `ZEKBC_ASSERT_IMPLIES(a_no_add_in_clear, clock, reset, wr_en, !clear_busy)

endmodule

// ===== sv/zekbc_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zekbc_acc
// Accumulator memory with one registered read port, one write port, a
// write-to-read bypass and a clearing pass after reset.
// ----------------------------------------------------------------------------
module zekbc_acc #(
   parameter int STORE_BYTES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [$clog2(STORE_BYTES)-1:0] rd_addr,
   input  logic                           wr_en,
   input  logic [$clog2(STORE_BYTES)-1:0] wr_addr,
   input  logic [7:0]                     wr_data,
   output logic [7:0]                     rd_data,
   output logic                           clear_busy
);
   localparam int ADDR_W = $clog2(STORE_BYTES);

   logic [7:0]        acc_mem [STORE_BYTES];
   logic [7:0]        rd_q_ff;
   logic              bypass_ff;
   logic              bypass_in;
   logic [7:0]        bypass_data_ff;
   logic [ADDR_W-1:0] clr_ptr_ff;
   logic [ADDR_W-1:0] clr_ptr_in;
   logic              clear_busy_ff;
   logic              clear_busy_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [7:0]        mem_wd;

   // The clearing pass owns the write port until every cell is zero.
   always_comb begin
      clr_ptr_in    = clr_ptr_ff;
      clear_busy_in = clear_busy_ff;
      if (clear_busy_ff) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == ADDR_W'(STORE_BYTES - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
      mem_we    = clear_busy_ff | wr_en;
      mem_wa    = clear_busy_ff ? clr_ptr_ff : wr_addr;
      mem_wd    = clear_busy_ff ? 8'd0 : wr_data;
      bypass_in = wr_en && (wr_addr == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff    <= '0;
         clear_busy_ff <= 1'b1;
      end else begin
         clr_ptr_ff    <= clr_ptr_in;
         clear_busy_ff <= clear_busy_in;
      end
   end

   // Memory array: the read returns the old contents on a same-cell write.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         acc_mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_q_ff <= acc_mem[rd_addr];
      end
   end

   // Catch a write landing on the cell being read in the same cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         bypass_ff      <= bypass_in;
         bypass_data_ff <= wr_data;
      end
   end

   assign rd_data    = bypass_ff ? bypass_data_ff : rd_q_ff;
   assign clear_busy = clear_busy_ff;

endmodule

// ===== sv/zekbc_walk.sv =====
`timescale 1ns / 1ps
`include "zip_entry_keyed_byte_checksum_defines.svh"
// ----------------------------------------------------------------------------
// zekbc_walk
// Local file header walker: parses archive bytes, picks entries by name
// suffix and produces the accumulator cell and addend for each data byte.
// ----------------------------------------------------------------------------
module zekbc_walk #(
   parameter int STORE_BYTES = 256,
   parameter int NAME_LIMIT  = 511
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           byte_strobe,
   input  logic [7:0]                     byte_value,
   input  logic                           end_of_archive,
   output zekbc_pkg::walk_out_type        walk_out,
   output logic [$clog2(STORE_BYTES)-1:0] add_cell
);
   import zekbc_pkg::*;

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int NAME_W = $clog2(NAME_LIMIT + 1);

   localparam logic [2:0] PH_SIG   = 3'd0;
   localparam logic [2:0] PH_HDR   = 3'd1;
   localparam logic [2:0] PH_NAME  = 3'd2;
   localparam logic [2:0] PH_EXTRA = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_DESC  = 3'd5;
   localparam logic [2:0] PH_DONE  = 3'd6;

   logic [2:0]        phase_ff, phase_in;
   logic [31:0]       count_ff, count_in;
   logic [31:0]       sig_ff, sig_in;
   logic              desc_flag_ff, desc_flag_in;
   logic [31:0]       comp_len_ff, comp_len_in;
   logic [7:0]        name_lo_ff, name_lo_in;
   logic [NAME_W-1:0] name_len_ff, name_len_in;
   logic [15:0]       extra_len_ff, extra_len_in;
   logic [7:0]        tail_ff [TAIL_MAX];
   logic [7:0]        tail_in [TAIL_MAX];
   logic [3:0]        tail_count_ff, tail_count_in;
   logic              name_ended_ff, name_ended_in;
   logic              selected_ff, selected_in;
   logic [ADDR_W-1:0] cell_ff, cell_in;
   logic [2:0]        key_idx_ff, key_idx_in;
   logic [1:0]        status_ff, status_in;

   logic              to_name, to_extra, to_data, to_desc, to_sig;
   logic              owed;
   logic [31:0]       count_inc;
   logic [15:0]       name_full;
   logic [87:0]       tail_vec;

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      sig_in        = sig_ff;
      desc_flag_in  = desc_flag_ff;
      comp_len_in   = comp_len_ff;
      name_lo_in    = name_lo_ff;
      name_len_in   = name_len_ff;
      extra_len_in  = extra_len_ff;
      tail_in       = tail_ff;
      tail_count_in = tail_count_ff;
      name_ended_in = name_ended_ff;
      selected_in   = selected_ff;
      cell_in       = cell_ff;
      key_idx_in    = key_idx_ff;
      status_in     = status_ff;
      to_name       = 1'b0;
      to_extra      = 1'b0;
      to_data       = 1'b0;
      to_desc       = 1'b0;
      to_sig        = 1'b0;
      owed          = 1'b0;
      tail_vec      = '0;
      count_inc     = count_ff + 32'd1;
      name_full     = {byte_value, name_lo_ff};
      walk_out.add_en = 1'b0;
      walk_out.addend = KEY_BYTES[{~key_idx_ff, 3'b000} +: 8] ^ byte_value;

      if (byte_strobe && (phase_ff != PH_DONE)) begin
         count_in = count_inc;

         // Per-phase handling of the byte.
         unique case (phase_ff)
            PH_SIG: begin
               sig_in = {byte_value, sig_ff[31:8]};
               if (count_inc >= 32'(SIG_BYTES)) begin
                  if (sig_in == LOCAL_MAGIC) begin
                     phase_in      = PH_HDR;
                     count_in      = '0;
                     desc_flag_in  = 1'b0;
                     comp_len_in   = '0;
                     name_lo_in    = '0;
                     name_len_in   = '0;
                     extra_len_in  = '0;
                     tail_count_in = '0;
                     name_ended_in = 1'b0;
                     selected_in   = 1'b0;
                     cell_in       = '0;
                     key_idx_in    = '0;
                     for (int k = 0; k < TAIL_MAX; k++) begin
                        tail_in[k] = 8'd0;
                     end
                  end else begin
                     phase_in  = PH_DONE;
                     status_in = STATUS_FINISHED;
                  end
               end
            end
            PH_HDR: begin
               unique case (count_ff[4:0])
                  HDR_FLAGS_POS:        desc_flag_in        = byte_value[3];
                  HDR_CSIZE_POS:        comp_len_in[7:0]    = byte_value;
                  HDR_CSIZE_POS + 5'd1: comp_len_in[15:8]   = byte_value;
                  HDR_CSIZE_POS + 5'd2: comp_len_in[23:16]  = byte_value;
                  HDR_CSIZE_POS + 5'd3: comp_len_in[31:24]  = byte_value;
                  HDR_NLEN_POS:         name_lo_in          = byte_value;
                  HDR_NLEN_POS + 5'd1: begin
                     if (name_full > 16'(NAME_LIMIT)) begin
                        name_len_in = NAME_W'(NAME_LIMIT);
                     end else begin
                        name_len_in = NAME_W'(name_full);
                     end
                  end
                  HDR_XLEN_POS:         extra_len_in[7:0]   = byte_value;
                  HDR_XLEN_POS + 5'd1:  extra_len_in[15:8]  = byte_value;
                  default: ;
               endcase
               if (count_inc >= 32'(HEADER_BYTES)) begin
                  to_name = 1'b1;
               end
            end
            PH_NAME: begin
               // Keep the last characters of the name up to its first NUL.
               if (!name_ended_ff) begin
                  if (byte_value == 8'd0) begin
                     name_ended_in = 1'b1;
                  end else begin
                     for (int k = 0; k < TAIL_MAX - 1; k++) begin
                        tail_in[k] = tail_ff[k + 1];
                     end
                     tail_in[TAIL_MAX - 1] = byte_value;
                     if (tail_count_ff < 4'(TAIL_MAX)) begin
                        tail_count_in = tail_count_ff + 4'd1;
                     end
                  end
               end
               if (count_inc >= 32'(name_len_ff)) begin
                  to_extra = 1'b1;
               end
            end
            PH_EXTRA: begin
               if (count_inc >= 32'(extra_len_ff)) begin
                  to_data = 1'b1;
               end
            end
            PH_DATA: begin
               if (selected_ff) begin
                  walk_out.add_en = 1'b1;
                  key_idx_in      = key_idx_ff + 3'd1;
                  if (cell_ff == ADDR_W'(STORE_BYTES - 1)) begin
                     cell_in = '0;
                  end else begin
                     cell_in = cell_ff + 1'b1;
                  end
               end
               if (count_inc >= comp_len_ff) begin
                  to_desc = 1'b1;
               end
            end
            PH_DESC: begin
               if (count_inc >= 32'(DESC_BYTES)) begin
                  to_sig = 1'b1;
               end
            end
            default: ;
         endcase

         // Move to the next part of the entry, skipping empty parts.
         if (to_name) begin
            count_in = '0;
            if (name_len_in != '0) begin
               phase_in = PH_NAME;
            end else begin
               to_extra = 1'b1;
            end
         end
         if (to_extra) begin
            count_in = '0;
            for (int k = 0; k < TAIL_MAX; k++) begin
               tail_vec[8 * (TAIL_MAX - 1 - k) +: 8] = tail_in[k];
            end
            selected_in = ((tail_count_in >= 4'd3) && (tail_vec[23:0] == SUFFIX_SO)) ||
                          ((tail_count_in >= 4'(TAIL_MAX)) && (tail_vec == SUFFIX_DEX));
            cell_in    = '0;
            key_idx_in = '0;
            if (extra_len_in != '0) begin
               phase_in = PH_EXTRA;
            end else begin
               to_data = 1'b1;
            end
         end
         if (to_data) begin
            count_in = '0;
            if (comp_len_in != '0) begin
               phase_in = PH_DATA;
            end else begin
               to_desc = 1'b1;
            end
         end
         if (to_desc) begin
            count_in = '0;
            if (desc_flag_in) begin
               phase_in = PH_DESC;
            end else begin
               to_sig = 1'b1;
            end
         end
         if (to_sig) begin
            count_in = '0;
            phase_in = PH_SIG;
            sig_in   = '0;
         end

         // The last archive byte closes the walk; owed bytes mean truncation.
         if (end_of_archive && (phase_in != PH_DONE)) begin
            owed = ((phase_in == PH_HDR) && (count_in >= 32'(NAME_OWED_POS)) &&
                    (name_len_in != '0)) ||
                   (phase_in == PH_NAME) ||
                   ((phase_in == PH_EXTRA) && selected_in && (comp_len_in != '0)) ||
                   ((phase_in == PH_DATA) && selected_in);
            status_in = owed ? STATUS_TRUNCATED : STATUS_FINISHED;
            phase_in  = PH_DONE;
         end
      end

      walk_out.walk_status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIG;
         count_ff      <= '0;
         sig_ff        <= '0;
         desc_flag_ff  <= 1'b0;
         comp_len_ff   <= '0;
         name_lo_ff    <= '0;
         name_len_ff   <= '0;
         extra_len_ff  <= '0;
         tail_count_ff <= '0;
         name_ended_ff <= 1'b0;
         selected_ff   <= 1'b0;
         cell_ff       <= '0;
         key_idx_ff    <= '0;
         status_ff     <= STATUS_WALKING;
         for (int k = 0; k < TAIL_MAX; k++) begin
            tail_ff[k] <= 8'd0;
         end
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         sig_ff        <= sig_in;
         desc_flag_ff  <= desc_flag_in;
         comp_len_ff   <= comp_len_in;
         name_lo_ff    <= name_lo_in;
         name_len_ff   <= name_len_in;
         extra_len_ff  <= extra_len_in;
         tail_count_ff <= tail_count_in;
         name_ended_ff <= name_ended_in;
         selected_ff   <= selected_in;
         cell_ff       <= cell_in;
         key_idx_ff    <= key_idx_in;
         status_ff     <= status_in;
         tail_ff       <= tail_in;
      end
   end

   assign add_cell = cell_ff;

   // A finished walk keeps its status until reset.
   `ZEKBC_ASSERT_NEXT(a_status_sticky, clock, reset, status_ff != STATUS_WALKING, $stable(status_ff))
   // The walk only rests in its done phase with a final status.
   `ZEKBC_ASSERT_IMPLIES(a_done_has_status, clock, reset, phase_ff == PH_DONE, status_ff != STATUS_WALKING)

endmodule

// ===== test/zekbc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zekbc_checker
// Watches both channels of the keyed byte checksum block, keeps its own copy
// of the archive walker and accumulator, and compares every response field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module zekbc_checker
   import zekbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      waiting_count
);

   localparam int NAME_CAP = 511;

   // Where the walker stands inside the chain of local headers.
   typedef enum logic [2:0] {
      WALK_SIG, WALK_HDR, WALK_NAME, WALK_EXTRA, WALK_DATA, WALK_DESC, WALK_DONE
   } walk_phase_type;

   // Shadow state of the block.
   logic [7:0]              cell_sum [256];
   walk_phase_type          walk_phase;
   logic [31:0]             part_pos;
   logic [31:0]             sig_window;
   logic                    desc_pending;
   logic [31:0]             data_len;
   logic [8:0]              name_len;
   logic [15:0]             extra_len;
   logic [8*TAIL_MAX-1:0]   tail_chars;
   int                      tail_fill;
   logic                    name_stop;
   logic                    entry_counted;
   logic [7:0]              data_pos;
   logic [1:0]              walk_state;

   // Responses predicted but not yet seen, oldest first.
   rsp_type                 owed_responses [$];

   function automatic void clear_walker();
      int k;
      for (k = 0; k < 256; k++) cell_sum[k] = 8'h00;
      walk_phase    = WALK_SIG;
      part_pos      = '0;
      sig_window    = '0;
      desc_pending  = 1'b0;
      data_len      = '0;
      name_len      = '0;
      extra_len     = '0;
      tail_chars    = '0;
      tail_fill     = 0;
      name_stop     = 1'b0;
      entry_counted = 1'b0;
      data_pos      = '0;
      walk_state    = STATUS_WALKING;
   endfunction

   // Step into the given part of an entry, passing over empty parts.
   function automatic void open_part(walk_phase_type p);
      walk_phase_type next;
      next = p;
      part_pos = '0;
      if (next == WALK_NAME) begin
         if (name_len != 0) begin
            walk_phase = WALK_NAME;
            return;
         end
         next = WALK_EXTRA;
      end
      if (next == WALK_EXTRA) begin
         entry_counted = (tail_fill >= 3 && tail_chars[23:0] == SUFFIX_SO) ||
                         (tail_fill >= TAIL_MAX && tail_chars == SUFFIX_DEX);
         data_pos = '0;
         if (extra_len != 0) begin
            walk_phase = WALK_EXTRA;
            return;
         end
         next = WALK_DATA;
      end
      if (next == WALK_DATA) begin
         if (data_len != 0) begin
            walk_phase = WALK_DATA;
            return;
         end
         next = WALK_DESC;
      end
      if (next == WALK_DESC && desc_pending) begin
         walk_phase = WALK_DESC;
         return;
      end
      walk_phase = WALK_SIG;
      sig_window = '0;
   endfunction

   // Advance the walker by one archive byte.
   function automatic void walk_byte(logic [7:0] b);
      logic [31:0] pos;
      logic [15:0] raw_len;
      pos = part_pos;
      case (walk_phase)
         WALK_SIG: begin
            sig_window = {b, sig_window[31:8]};
            part_pos++;
            if (part_pos >= SIG_BYTES) begin
               if (sig_window == LOCAL_MAGIC) begin
                  walk_phase    = WALK_HDR;
                  part_pos      = '0;
                  desc_pending  = 1'b0;
                  data_len      = '0;
                  name_len      = '0;
                  extra_len     = '0;
                  tail_chars    = '0;
                  tail_fill     = 0;
                  name_stop     = 1'b0;
                  entry_counted = 1'b0;
                  data_pos      = '0;
               end else begin
                  walk_phase = WALK_DONE;
                  walk_state = STATUS_FINISHED;
               end
            end
         end
         WALK_HDR: begin
            if (pos == HDR_FLAGS_POS) begin
               desc_pending = b[3];
            end else if (pos >= HDR_CSIZE_POS && pos <= HDR_CSIZE_POS + 3) begin
               data_len = data_len | (32'(b) << (8 * (pos - HDR_CSIZE_POS)));
            end else if (pos == HDR_NLEN_POS) begin
               name_len = 9'(b);
            end else if (pos == HDR_NLEN_POS + 1) begin
               raw_len = {b, name_len[7:0]};
               name_len = (raw_len > NAME_CAP) ? 9'(NAME_CAP) : raw_len[8:0];
            end else if (pos == HDR_XLEN_POS) begin
               extra_len = 16'(b);
            end else if (pos == HDR_XLEN_POS + 1) begin
               extra_len = {b, extra_len[7:0]};
            end
            part_pos++;
            if (part_pos >= HEADER_BYTES) open_part(WALK_NAME);
         end
         WALK_NAME: begin
            // Only the part before the first NUL byte decides selection.
            if (!name_stop) begin
               if (b == 8'h00) begin
                  name_stop = 1'b1;
               end else begin
                  tail_chars = {tail_chars[8*TAIL_MAX-9:0], b};
                  if (tail_fill < TAIL_MAX) tail_fill++;
               end
            end
            part_pos++;
            if (part_pos >= name_len) open_part(WALK_EXTRA);
         end
         WALK_EXTRA: begin
            part_pos++;
            if (part_pos >= extra_len) open_part(WALK_DATA);
         end
         WALK_DATA: begin
            if (entry_counted) begin
               cell_sum[data_pos] = cell_sum[data_pos] +
                                    (KEY_BYTES[8 * (7 - data_pos[2:0]) +: 8] ^ b);
               data_pos++;
            end
            part_pos++;
            if (part_pos >= data_len) open_part(WALK_DESC);
         end
         WALK_DESC: begin
            part_pos++;
            if (part_pos >= DESC_BYTES) open_part(WALK_SIG);
         end
         default: begin
         end
      endcase
   endfunction

   // The archive ended on this byte: decide whether bytes were still owed.
   function automatic void close_walk();
      logic owed;
      owed = (walk_phase == WALK_HDR && part_pos >= NAME_OWED_POS && name_len != 0) ||
             (walk_phase == WALK_NAME) ||
             (walk_phase == WALK_EXTRA && entry_counted && data_len != 0) ||
             (walk_phase == WALK_DATA && entry_counted);
      walk_state = owed ? STATUS_TRUNCATED : STATUS_FINISHED;
      walk_phase = WALK_DONE;
   endfunction

   // Expected response for one request, updating the shadow state.
   function automatic rsp_type checksum_step(req_type r);
      rsp_type o;
      o.checksum_byte = 8'h00;
      if (r.kind == KIND_READ) begin
         o.checksum_byte = cell_sum[r.read_index];
      end else if (walk_phase != WALK_DONE) begin
         walk_byte(r.byte_value);
         if (r.end_of_archive && walk_phase != WALK_DONE) close_walk();
      end
      o.walk_status = walk_state;
      return o;
   endfunction

   // Predict on every accepted request, compare on every accepted response.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_walker();
         owed_responses.delete();
      end else begin
         if (req_valid && !req_stall) begin
            owed_responses.push_back(checksum_step(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_responses.size() == 0) begin
               $display("%0t: response with none outstanding, got byte %02h status %0d",
                        $time, rsp_data.checksum_byte, rsp_data.walk_status);
               fail_count++;
            end else begin
               want = owed_responses.pop_front();
               if (rsp_data.checksum_byte !== want.checksum_byte) begin
                  $display("%0t: checksum_byte expected %02h, got %02h",
                           $time, want.checksum_byte, rsp_data.checksum_byte);
                  fail_count++;
               end
               if (rsp_data.walk_status !== want.walk_status) begin
                  $display("%0t: walk_status expected %0d, got %0d",
                           $time, want.walk_status, rsp_data.walk_status);
                  fail_count++;
               end
            end
         end
      end
      waiting_count = owed_responses.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams one long ZIP archive through the keyed byte checksum block, with
// accumulator reads mixed in, under varying handshake gaps and one long
// response hold-off, then reads back every cell and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import zekbc_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;

   // How an entry is closed off when it ends the archive.
   typedef enum int {END_NONE, END_LAST, END_RANDOM, END_IN_DATA} end_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      fail_count;
   int      waiting_count;

   int      send_gap_pct = 11;
   int      rsp_gap_pct  = 60;
   logic    hold_ask     = 1'b0;

   req_type    req_plan [$];
   logic [7:0] name_buf [$];
   int         bytes_planned   = 0;
   int         reads_planned   = 0;
   int         entries_planned = 0;

   always #6 clock = ~clock;

   zip_entry_keyed_byte_checksum DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   zekbc_checker response_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .waiting_count (waiting_count)
   );

   // Queue a read of one accumulator cell; the end marker on a read is noise.
   task automatic push_read(input logic [7:0] idx, input logic last);
      req_type r;
      r.kind           = KIND_READ;
      r.byte_value     = 8'($urandom_range(255));
      r.end_of_archive = last;
      r.read_index     = idx;
      req_plan.push_back(r);
      reads_planned++;
   endtask

   // Queue one archive byte, sometimes followed by a read of a cell, most often a low one.
   task automatic push_byte(input logic [7:0] b, input logic last);
      req_type r;
      r.kind           = KIND_BYTE;
      r.byte_value     = b;
      r.end_of_archive = last;
      r.read_index     = 8'($urandom_range(255));
      req_plan.push_back(r);
      bytes_planned++;
      if ($urandom_range(99) < 8) begin
         push_read(($urandom_range(99) < 70) ? 8'($urandom_range(31))
                                              : 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end
   endtask

   task automatic add_text(input string s);
      int k;
      for (k = 0; k < s.len(); k++) name_buf.push_back(s[k]);
   endtask

   // Build a whole local header entry from name_buf and queue it, possibly
   // cut short with the end marker on its last queued byte.
   task automatic add_entry(input logic [7:0] flag_byte, input logic [15:0] name_field,
                            input int extra_n, input int data_n, input end_mode_type mode);
      logic [7:0]  entry_buf [$];
      logic [31:0] csize;
      logic [15:0] xlen;
      int          k;
      int          stop;
      int          data_start;
      csize = 32'(data_n);
      xlen  = 16'(extra_n);
      for (k = 0; k < SIG_BYTES; k++) entry_buf.push_back(LOCAL_MAGIC[8*k +: 8]);
      for (k = 0; k < HEADER_BYTES; k++) begin
         if (k == HDR_FLAGS_POS)
            entry_buf.push_back(flag_byte);
         else if (k >= HDR_CSIZE_POS && k <= HDR_CSIZE_POS + 3)
            entry_buf.push_back(csize[8*(k - HDR_CSIZE_POS) +: 8]);
         else if (k == HDR_NLEN_POS)
            entry_buf.push_back(name_field[7:0]);
         else if (k == HDR_NLEN_POS + 1)
            entry_buf.push_back(name_field[15:8]);
         else if (k == HDR_XLEN_POS)
            entry_buf.push_back(xlen[7:0]);
         else if (k == HDR_XLEN_POS + 1)
            entry_buf.push_back(xlen[15:8]);
         else
            entry_buf.push_back(8'($urandom_range(255)));
      end
      for (k = 0; k < name_buf.size(); k++) entry_buf.push_back(name_buf[k]);
      data_start = entry_buf.size() + extra_n;
      for (k = 0; k < extra_n + data_n; k++) entry_buf.push_back(8'($urandom_range(255)));
      if (flag_byte[3]) begin
         for (k = 0; k < DESC_BYTES; k++) entry_buf.push_back(8'($urandom_range(255)));
      end
      case (mode)
         END_RANDOM:  stop = $urandom_range(1, entry_buf.size());
         END_IN_DATA: stop = (data_n > 1) ? data_start + $urandom_range(1, data_n - 1)
                                          : entry_buf.size();
         default:     stop = entry_buf.size();
      endcase
      for (k = 0; k < stop; k++) push_byte(entry_buf[k], (mode != END_NONE) && (k == stop - 1));
      entries_planned++;
   endtask

   // Fill name_buf with a name that may or may not select the entry.
   task automatic pick_name();
      int choice;
      int k;
      int n;
      name_buf.delete();
      choice = $urandom_range(13);
      case (choice)
         0:  add_text("lib/arm64-v8a/libmain.so");
         1:  add_text("classes.dex");
         2:  add_text("x/classes.dex");
         3:  add_text("a.so");
         4:  add_text(".so");
         5:  add_text("readme.txt");
         6:  add_text("libfoo.so.1");
         7:  add_text("Classes.dex");
         8:  add_text("lasses.dex");
         9: begin
            // Selected: the part after the NUL does not count.
            add_text("a.so");
            name_buf.push_back(8'h00);
            add_text("junk");
         end
         10: begin
            add_text("abc");
            name_buf.push_back(8'h00);
            add_text(".so");
         end
         11: begin
            // Empty name, never selected.
         end
         12: begin
            n = $urandom_range(1, 16);
            for (k = 0; k < n; k++) name_buf.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) add_text(".so");
         end
         default: add_text("x.sO");
      endcase
   endtask

   task automatic random_entry(input end_mode_type mode);
      int extra_n;
      int data_n;
      int roll;
      pick_name();
      extra_n = ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 6);
      roll = $urandom_range(99);
      if (roll < 20)
         data_n = 0;
      else if (roll < 95)
         data_n = $urandom_range(1, 40);
      else
         data_n = $urandom_range(250, 270);
      add_entry(8'($urandom_range(255)), 16'(name_buf.size()), extra_n, data_n, mode);
   endtask

   // Offer one request and hold it until the block takes it.
   task automatic send_request(input req_type r);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Response side: random stalls, plus one long hold-off on request.
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rsp_gap_pct);
      end
   end

   // Ends the run when neither channel moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   initial begin : main
      int    k;
      int    third;
      string end_kind;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: reads of untouched cells, two with the end marker,
      // a minimal selected entry, and an entry with nothing but a descriptor.
      push_read(8'h00, 1'b1);
      push_read(8'hFF, 1'b0);
      push_read(8'hAA, 1'b0);
      push_read(8'h55, 1'b1);
      name_buf.delete();
      add_text(".so");
      add_entry(8'hF7, 16'(name_buf.size()), 0, 2, END_NONE);
      name_buf.delete();
      add_entry(8'h08, 16'd0, 0, 0, END_NONE);

      // Random well-formed entries.
      while (req_plan.size() < 280) begin
         random_entry(END_NONE);
      end

      // Close the walk one of several ways.
      case ($urandom_range(3))
         0: begin
            end_kind = "a non-matching signature";
            push_byte(LOCAL_MAGIC[7:0], 1'b0);
            push_byte(LOCAL_MAGIC[15:8], 1'b0);
            push_byte(8'h01, 1'b0);
            push_byte(8'h02, 1'($urandom_range(1)));
         end
         1: begin
            end_kind = "an end marker at a random byte of an entry";
            random_entry(END_RANDOM);
         end
         2: begin
            end_kind = "an end marker inside selected data";
            name_buf.delete();
            add_text("lib/t.so");
            add_entry(8'($urandom_range(255)), 16'(name_buf.size()), 0, 40, END_IN_DATA);
         end
         default: begin
            end_kind = "an end marker on the last byte of an entry";
            random_entry(END_LAST);
         end
      endcase

      // Bytes after the walk is over are ignored; then read every cell.
      for (k = 0; k < 24; k++) begin
         if ($urandom_range(1))
            push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         else
            push_read(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      for (k = 0; k < 256; k++) push_read(8'(k), 1'b0);

      // Drive the plan: sender-light gaps, then receiver-light, then none
      // with one long response hold-off.
      third = req_plan.size() / 3;
      for (k = 0; k < req_plan.size(); k++) begin
         if (k == third) begin
            send_gap_pct = 60;
            rsp_gap_pct  = 11;
         end else if (k == 2 * third) begin
            send_gap_pct = 0;
            rsp_gap_pct  = 0;
            hold_ask <= 1'b1;
         end
         send_request(req_plan[k]);
      end
      req_valid <= 1'b0;

      while (waiting_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("summary: %0d archive bytes and %0d accumulator reads over %0d local headers",
               bytes_planned, reads_planned, entries_planned);
      $display("summary: walk closed by %s, then all cells read back", end_kind);
      if (fail_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/zekbc_pkg.sv
sv/zekbc_acc.sv
sv/zekbc_walk.sv
sv/zip_entry_keyed_byte_checksum.sv
test/zekbc_checker.sv
test/testbench.sv
